// File: hdl/cpi_pkg.sv
// Shared types and constants for the color palette indexer.
package cpi_pkg;

    localparam int PIX_W       = 32;
    localparam int IDX_W       = 8;
    localparam int CNT_W       = 9;
    localparam int TABLE_DEPTH = 256;

    typedef struct packed {
        logic [PIX_W-1:0] pixel_value;
        logic             start_of_image;
    } t_pix_in;

    typedef struct packed {
        logic [IDX_W-1:0] color_index;
        logic             is_new_color;
        logic             palette_overflow;
        logic [CNT_W-1:0] palette_count;
    } t_pix_out;

    // Request from the search engine to the color table
    typedef struct packed {
        logic                            wr_en;
        logic [$clog2(TABLE_DEPTH)-1:0]  addr;
        logic [PIX_W-1:0]                wr_data;
    } t_mem_req;

endpackage

// File: hdl/cpi_ram.sv
// Generic single-port RAM with registered read data.
module cpi_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: hdl/cpi_engine.sv
// Search engine: scans the color table, appends misses, builds the result.
module cpi_engine #(
    parameter int PALETTE_SIZE = 256
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  cpi_pkg::t_pix_in  i_in_data,
    output cpi_pkg::t_mem_req o_mem_req,
    input  logic [31:0]       i_mem_rdata,
    input  logic              i_slot_free,
    output logic              o_res_valid,
    output cpi_pkg::t_pix_out o_res
);
    import cpi_pkg::*;

    localparam logic [CNT_W-1:0] LIMIT = CNT_W'(PALETTE_SIZE);
    localparam int AW = $clog2(TABLE_DEPTH);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_DONE = 3'b100
    } t_state;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_count, n_count;
    logic [CNT_W-1:0] r_addr, n_addr;
    logic             r_rd_vld, n_rd_vld;
    logic [AW-1:0]    r_rd_idx, n_rd_idx;
    logic [PIX_W-1:0] r_pixel, n_pixel;
    t_pix_out         r_res, n_res;
    t_mem_req         mem_req;

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_addr   = r_addr;
        n_rd_vld = 1'b0;
        n_rd_idx = r_rd_idx;
        n_pixel  = r_pixel;
        n_res    = r_res;
        mem_req  = '{wr_en: 1'b0, addr: r_addr[AW-1:0], wr_data: r_pixel};

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_pixel = i_in_data.pixel_value;
                    n_addr  = '0;
                    if (i_in_data.start_of_image) begin
                        n_count = '0;
                    end
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                // one read issued per cycle; the compare uses the registered RAM read data, flagged by r_rd_vld
                if (r_addr < r_count) begin
                    n_rd_vld = 1'b1;
                    n_rd_idx = r_addr[AW-1:0];
                    n_addr   = r_addr + 1'b1;
                end
                if (r_rd_vld && i_mem_rdata == r_pixel) begin
                    n_res   = '{color_index: r_rd_idx, is_new_color: 1'b0,
                                palette_overflow: 1'b0, palette_count: r_count};
                    n_state = S_DONE;
                end else if (!r_rd_vld && r_addr >= r_count) begin
                    // miss: append if room, port is free this cycle
                    if (r_count < LIMIT) begin
                        mem_req = '{wr_en: 1'b1, addr: r_count[AW-1:0],
                                    wr_data: r_pixel};
                        n_count = r_count + 1'b1;
                        n_res   = '{color_index: r_count[AW-1:0], is_new_color: 1'b1,
                                    palette_overflow: 1'b0, palette_count: n_count};
                    end else begin
                        n_res = '{color_index: '0, is_new_color: 1'b0,
                                  palette_overflow: 1'b1, palette_count: r_count};
                    end
                    n_rd_vld = 1'b0;
                    n_state  = S_DONE;
                end
            end
            S_DONE: begin
                if (i_slot_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_rd_vld <= n_rd_vld;
        end
        r_addr   <= n_addr;
        r_rd_idx <= n_rd_idx;
        r_pixel  <= n_pixel;
        r_res    <= n_res;
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_mem_req   = mem_req;
    assign o_res_valid = (r_state == S_DONE);
    assign o_res       = r_res;

endmodule

// File: hdl/color_palette_indexer_unit.sv
// Top level of the color palette indexer: table RAM, search engine, output register.
//
//   channel | valid      | ready       | payload
//   --------+------------+-------------+-----------------------
//   input   | i_in_valid | o_in_ready  | i_in_data  (t_pix_in)
//   output  | o_out_valid| i_out_ready | o_out_data (t_pix_out)
//
// After a transfer the engine scans the table until a hit at index k ends the scan, while a miss or an
// overflow scans every color in the table first; the result then passes through the output register.
// The scan reads the single-port table RAM one entry a cycle.
// After a result the engine returns to idle before the next pixel is taken.
// Reset empties the table by clearing the color count; the RAM itself is not cleared.
// A result waits in the output register; the engine holds its own result while
// that register is occupied, so the input stays open once the engine is idle.
module color_palette_indexer_unit #(
    parameter int PALETTE_SIZE = 256
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  cpi_pkg::t_pix_in  i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output cpi_pkg::t_pix_out o_out_data
);
    import cpi_pkg::*;

    t_mem_req    mem_req;
    logic [31:0] mem_rdata;
    logic        slot_free;
    logic        res_valid;
    t_pix_out    res;
    logic        r_out_valid;
    t_pix_out    r_out_data;

    cpi_ram #(
        .WIDTH (PIX_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (mem_req.wr_en),
        .i_addr  (mem_req.addr),
        .i_wdata (mem_req.wr_data),
        .o_rdata (mem_rdata)
    );

    cpi_engine #(
        .PALETTE_SIZE (PALETTE_SIZE)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_mem_req   (mem_req),
        .i_mem_rdata (mem_rdata),
        .i_slot_free (slot_free),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    assign slot_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (slot_free) begin
            r_out_valid <= res_valid;
        end
        if (slot_free && res_valid) begin
            r_out_data <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

// File: tb/tb.sv
// Self-checking testbench for color_palette_indexer_unit, with a scoreboard that predicts each result.
module tb;
    import cpi_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int PAL_SIZE   = 256;
    localparam int PAL_LIMIT  = (PAL_SIZE < TABLE_DEPTH) ? PAL_SIZE : TABLE_DEPTH;
    localparam int RAND_ITEMS = 1500;
    localparam int TAIL_ITEMS = 120;
    localparam int DRAIN_CYC  = TABLE_DEPTH + 40;
    localparam int CYCLE_CAP  = 3_000_000;

    logic     i_clk       = 1'b0;
    logic     i_rst_n     = 1'b0;
    logic     i_in_valid  = 1'b0;
    t_pix_in  i_in_data   = '0;
    logic     i_out_ready = 1'b0;
    logic     o_in_ready;
    logic     o_out_valid;
    t_pix_out o_out_data;

    t_pix_in     pix_pending [$];
    t_pix_out    idx_expected [$];
    logic [31:0] pal_tab [0:TABLE_DEPTH-1];
    int unsigned pal_cnt     = 0;
    int unsigned n_items     = 0;
    int unsigned n_accepted  = 0;
    int unsigned n_errors    = 0;
    int unsigned cycle_cnt   = 0;
    int unsigned in_gap      = 0;
    int unsigned out_hold    = 0;
    logic        quiet       = 1'b0;

    color_palette_indexer_unit #(
        .PALETTE_SIZE(PAL_SIZE)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_data (o_out_data)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    task automatic add_px(input logic [31:0] value, input logic sof);
        t_pix_in px;
        px.pixel_value    = value;
        px.start_of_image = sof;
        pix_pending.insert(pix_pending.size(), px);
    endtask

    // Scoreboard model: search the color table, append on a miss, flag overflow when full.
    task automatic index_pixel(input t_pix_in px);
        t_pix_out res;
        int       hit;
        int       k;
        hit = -1;
        res = '0;
        if (px.start_of_image)
            pal_cnt = 0;
        for (k = 0; k < pal_cnt; k++) begin
            if (hit < 0 && pal_tab[k] == px.pixel_value)
                hit = k;
        end
        if (hit >= 0) begin
            res.color_index = IDX_W'(hit);
        end else if (pal_cnt < PAL_LIMIT) begin
            pal_tab[pal_cnt]   = px.pixel_value;
            res.color_index    = IDX_W'(pal_cnt);
            res.is_new_color   = 1'b1;
            pal_cnt++;
        end else begin
            res.palette_overflow = 1'b1;
        end
        res.palette_count = CNT_W'(pal_cnt);
        idx_expected.insert(idx_expected.size(), res);
    endtask

    task automatic check_result(input t_pix_out got);
        t_pix_out exp_res;
        if (idx_expected.size() == 0) begin
            $error("unexpected result transfer: %p", got);
            n_errors++;
        end else begin
            exp_res = idx_expected.pop_front();
            if (got.color_index !== exp_res.color_index) begin
                $error("color_index: expected %0d, got %0d", exp_res.color_index,
                       got.color_index);
                n_errors++;
            end
            if (got.is_new_color !== exp_res.is_new_color) begin
                $error("is_new_color: expected %0d, got %0d", exp_res.is_new_color,
                       got.is_new_color);
                n_errors++;
            end
            if (got.palette_overflow !== exp_res.palette_overflow) begin
                $error("palette_overflow: expected %0d, got %0d", exp_res.palette_overflow,
                       got.palette_overflow);
                n_errors++;
            end
            if (got.palette_count !== exp_res.palette_count) begin
                $error("palette_count: expected %0d, got %0d", exp_res.palette_count,
                       got.palette_count);
                n_errors++;
            end
        end
    endtask

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_CAP) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // switches both sides between bursty and steady stretches
    always @(posedge i_clk) begin
        if ($urandom_range(0, 399) == 0)
            quiet <= !quiet;
    end

    // input driver; no new random gaps once the stimulus is nearly used up
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            in_gap     <= 0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                index_pixel(i_in_data);
                n_accepted++;
            end
            if (!i_in_valid || o_in_ready) begin
                if (in_gap != 0) begin
                    i_in_valid <= 1'b0;
                    in_gap     <= in_gap - 1;
                end else if (!quiet && pix_pending.size() >= TAIL_ITEMS
                             && $urandom_range(0, 5) == 0) begin
                    i_in_valid <= 1'b0;
                    in_gap     <= $urandom_range(0, 9);
                end else if (pix_pending.size() != 0) begin
                    i_in_valid <= 1'b1;
                    i_in_data  <= pix_pending.pop_front();
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // output monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            out_hold    <= 0;
        end else begin
            if (o_out_valid && i_out_ready)
                check_result(o_out_data);
            if (out_hold != 0) begin
                i_out_ready <= 1'b0;
                out_hold    <= out_hold - 1;
            end else if (!quiet && pix_pending.size() >= TAIL_ITEMS
                         && $urandom_range(0, 5) == 0) begin
                i_out_ready <= 1'b0;
                out_hold    <= $urandom_range(0, 9);
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    initial begin
        logic [31:0] pool [0:79];
        logic [31:0] base;
        logic [31:0] mult;
        int unsigned n_dir;
        int unsigned pool_n;
        int unsigned len;
        int unsigned img;
        logic        did_mid_fill;
        int          k;

        // directed: extreme words, hits, misses, start of image
        add_px(32'h0000_0000, 1'b0);
        add_px(32'hFFFF_FFFF, 1'b0);
        add_px(32'h0000_0000, 1'b0);
        add_px(32'hFFFF_FFFF, 1'b0);
        add_px(32'h8000_0000, 1'b0);
        add_px(32'h0000_0001, 1'b0);
        add_px(32'h8000_0000, 1'b0);
        add_px(32'hFFFF_FFFF, 1'b1);
        add_px(32'h0000_0000, 1'b0);
        add_px(32'hFFFF_FFFF, 1'b0);
        add_px(32'hFFFF_FFFF, 1'b1);
        add_px(32'hFFFF_FFFF, 1'b0);
        add_px(32'hA5A5_A5A5, 1'b1);
        add_px(32'h5A5A_5A5A, 1'b0);
        add_px(32'hA5A5_A5A5, 1'b0);
        add_px(32'h5A5A_5A5A, 1'b0);
        add_px(32'h7FFF_FFFF, 1'b0);
        add_px(32'h0000_0000, 1'b0);
        add_px(32'h7FFF_FFFF, 1'b0);
        n_dir = pix_pending.size();

        img          = 0;
        did_mid_fill = 1'b0;
        while (pix_pending.size() < n_dir + RAND_ITEMS) begin
            if (img == 0 || (!did_mid_fill && pix_pending.size() >= n_dir + RAND_ITEMS / 2)) begin
                // fill the whole table, then mix overflowing misses with deep hits
                if (img != 0)
                    did_mid_fill = 1'b1;
                base = $urandom;
                mult = $urandom | 32'h1;
                for (k = 0; k < PAL_LIMIT; k++) begin
                    add_px(base ^ (32'(k) * mult), k == 0);
                    if (k > 0 && $urandom_range(0, 7) == 0)
                        add_px(base ^ (32'($urandom_range(0, k - 1)) * mult), 1'b0);
                end
                for (k = 0; k < 24; k++) begin
                    if ($urandom_range(0, 1) == 0)
                        add_px(base ^ (32'(PAL_LIMIT + k) * mult), 1'b0);
                    else
                        add_px(base ^ (32'($urandom_range(0, PAL_LIMIT - 1)) * mult), 1'b0);
                end
            end else begin
                pool_n = ($urandom_range(0, 6) == 0) ? $urandom_range(13, 80)
                                                     : $urandom_range(1, 12);
                for (k = 0; k < pool_n; k++) begin
                    case ($urandom_range(0, 9))
                        0: pool[k] = 32'h0000_0000;
                        1: pool[k] = 32'hFFFF_FFFF;
                        default: pool[k] = $urandom;
                    endcase
                end
                len = (pool_n > 12) ? $urandom_range(20, 120) : $urandom_range(1, 40);
                // mostly a clean image start; now and then a stray restart mid-image
                for (k = 0; k < len; k++)
                    add_px(pool[$urandom_range(0, pool_n - 1)],
                           (k == 0 && $urandom_range(0, 9) != 0) || $urandom_range(0, 49) == 0);
            end
            img++;
        end
        n_items = pix_pending.size();

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (n_accepted != n_items)
            @(posedge i_clk);
        while (idx_expected.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYC) @(posedge i_clk);

        if (idx_expected.size() != 0) begin
            $error("%0d expected results never arrived", idx_expected.size());
            n_errors++;
        end
        if (n_errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// File: filelist.f
hdl/cpi_pkg.sv
hdl/cpi_ram.sv
hdl/cpi_engine.sv
hdl/color_palette_indexer_unit.sv
tb/tb.sv
